@@ rtl/core/ips_pkg.sv @@
// shared types and constants for the integer prefix scan unit
// no dependencies

`default_nettype none

package ips_pkg;

    localparam int unsigned DATA_W = 32;

    localparam logic signed [DATA_W-1:0] NA_CODE = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam logic [1:0] MODE_SUM = 2'd0;
    localparam logic [1:0] MODE_MAX = 2'd1;
    localparam logic [1:0] MODE_MIN = 2'd2;

    localparam logic [2:0] ADDR_SCAN_MODE = 3'd0;

    typedef struct packed {
        logic signed [DATA_W-1:0] element;
        logic                     last_element;
    } ips_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] running_value;
        logic                     overflowed;
        logic                     last_result;
    } ips_out_t;

endpackage

`default_nettype wire

@@ rtl/core/integer_prefix_scan_unit.sv @@
// integer prefix scan unit: an accepted item goes from s_item to m_valid through
// the input register, then scan logic into the result register
// throughput one item per cycle; stalls only when the result register is held
// synchronous active-low reset empties both registers, clears the scan state
// and sets scan_mode to cumulative sum
// depends on ips_pkg, ips_cfg_regs, ips_scan_core

`default_nettype none

module integer_prefix_scan_unit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ips_pkg::ips_in_t s_item,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ips_pkg::ips_out_t     m_item,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import ips_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    ips_in_t    in_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    ips_out_t   out_item_reg;
    ips_out_t   scan_result;
    logic [1:0] scan_mode;
    logic       advance;
    logic       s_take;

    ips_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .scan_mode (scan_mode)
    );

    ips_scan_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .scan_mode (scan_mode),
        .item      (in_item_reg),
        .result    (scan_result)
    );

    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;
    assign s_take  = s_valid & s_ready;

    always_comb begin
        in_valid_next = s_take | (in_valid_reg & ~advance);
        out_valid_next = advance | (out_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= scan_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

`default_nettype wire

@@ rtl/core/ips_cfg_regs.sv @@
// apb configuration register block: holds scan_mode
// depends on ips_pkg

`default_nettype none

module ips_cfg_regs (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [1:0]       scan_mode
);
    import ips_pkg::*;

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic       wr_en;
    logic       sel_mode;

    assign pready   = 1'b1;
    assign sel_mode = (paddr[2] == ADDR_SCAN_MODE[2]);
    assign wr_en    = psel & penable & pwrite & pready;

    always_comb begin
        mode_next = mode_reg;
        if (wr_en && sel_mode) begin
            mode_next = pwdata[1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_SUM;
        end else begin
            mode_reg <= mode_next;
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (sel_mode) begin
            prdata = {30'd0, mode_reg};
        end
    end

    assign scan_mode = mode_reg;

endmodule

`default_nettype wire

@@ rtl/core/ips_scan_core.sv @@
// scan datapath: running sum, max or min with na and overflow tracking
// depends on ips_pkg

`default_nettype none

module ips_scan_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire logic [1:0]      scan_mode,
    input  wire ips_pkg::ips_in_t  item,
    output ips_pkg::ips_out_t      result
);
    import ips_pkg::*;

    logic signed [DATA_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] acc_next;
    logic                     halted_reg;
    logic                     halted_next;
    logic                     ovf_reg;
    logic                     ovf_next;
    logic                     first_reg;
    logic                     first_next;

    logic signed [DATA_W:0]   sum_wide;
    logic                     sum_out;
    logic signed [DATA_W-1:0] max_val;
    logic signed [DATA_W-1:0] min_val;

    assign sum_wide = {acc_reg[DATA_W-1], acc_reg} + {item.element[DATA_W-1], item.element};
    // out of range when it does not fit, or lands on the na code
    assign sum_out  = (sum_wide[DATA_W] != sum_wide[DATA_W-1])
                    || (sum_wide[DATA_W-1:0] == NA_CODE);
    assign max_val  = (acc_reg > item.element) ? acc_reg : item.element;
    assign min_val  = (acc_reg < item.element) ? acc_reg : item.element;

    always_comb begin
        acc_next             = acc_reg;
        halted_next          = halted_reg;
        ovf_next             = ovf_reg;
        first_next           = first_reg;
        result.running_value = NA_CODE;
        if (!halted_reg) begin
            first_next = 1'b0;
            if (item.element == NA_CODE) begin
                halted_next = 1'b1;
            end else begin
                unique case (scan_mode)
                    MODE_SUM: begin
                        if (sum_out) begin
                            halted_next = 1'b1;
                            ovf_next    = 1'b1;
                        end else begin
                            acc_next             = sum_wide[DATA_W-1:0];
                            result.running_value = sum_wide[DATA_W-1:0];
                        end
                    end
                    MODE_MAX: begin
                        acc_next             = first_reg ? item.element : max_val;
                        result.running_value = acc_next;
                    end
                    MODE_MIN: begin
                        acc_next             = first_reg ? item.element : min_val;
                        result.running_value = acc_next;
                    end
                    default: begin
                        halted_next = 1'b1;
                    end
                endcase
            end
        end
        result.overflowed  = ovf_next;
        result.last_result = item.last_element;
        if (item.last_element) begin
            acc_next    = '0;
            halted_next = 1'b0;
            ovf_next    = 1'b0;
            first_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            halted_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            first_reg  <= 1'b1;
        end else if (advance) begin
            acc_reg    <= acc_next;
            halted_reg <= halted_next;
            ovf_reg    <= ovf_next;
            first_reg  <= first_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for integer_prefix_scan_unit: directed table, then random vectors
// expected items from typed rows or an in-bench predictor, checked field by field in order
// depends on ips_pkg and the integer_prefix_scan_unit rtl

`default_nettype none

module tb;
    import ips_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int DIR_ROWS = 25;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_CAP = 40;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] SUM_FLOOR = NA_CODE + 1;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] element;
        logic                     last_element;
        logic                     typed;
        logic signed [DATA_W-1:0] want_value;
        logic                     want_ovf;
    } scan_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    ips_in_t     s_item;
    logic        m_valid;
    logic        m_ready;
    ips_out_t    m_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [1:0]               mode_q = MODE_SUM;
    logic signed [DATA_W-1:0] acc_q = '0;
    logic                     halt_q = 1'b0;
    logic                     ovf_q = 1'b0;
    logic                     first_q = 1'b1;

    ips_out_t  pending_results[$];
    scan_row_t dir_rows[DIR_ROWS];
    int        mismatch_count = 0;
    int        items_sent = 0;
    int        idle_cycles = 0;
    int        ready_hold = 0;
    bit        steady_flow = 1'b0;

    integer_prefix_scan_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk    = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        m_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
    end

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch: %s got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    function automatic ips_out_t predict_scan_result(input ips_in_t it);
        ips_out_t                 r;
        longint                   s;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] v;
        r.running_value = NA_CODE;
        v = it.element;
        if (!halt_q) begin
            if (v == NA_CODE || mode_q == MODE_UNUSED) begin
                halt_q = 1'b1;
            end else if (mode_q == MODE_SUM) begin
                s = longint'($signed(acc_q)) + longint'($signed(v));
                if (s > longint'($signed(INT_MAX)) || s < longint'($signed(SUM_FLOOR))) begin
                    halt_q = 1'b1;
                    ovf_q  = 1'b1;
                end else begin
                    acc_q = s[DATA_W-1:0];
                    r.running_value = acc_q;
                end
            end else begin
                a = acc_q;
                if (first_q)
                    a = v;
                else if (mode_q == MODE_MAX)
                    a = ($signed(a) > $signed(v)) ? a : v;
                else
                    a = ($signed(a) < $signed(v)) ? a : v;
                acc_q = a;
                r.running_value = acc_q;
            end
            first_q = 1'b0;
        end
        r.overflowed  = ovf_q;
        r.last_result = it.last_element;
        if (it.last_element) begin
            acc_q   = '0;
            halt_q  = 1'b0;
            ovf_q   = 1'b0;
            first_q = 1'b1;
        end
        return r;
    endfunction

    function automatic scan_row_t mk_row(input logic [1:0] mode,
                                         input logic signed [DATA_W-1:0] element,
                                         input logic last_element, input logic typed,
                                         input logic signed [DATA_W-1:0] want_value,
                                         input logic want_ovf);
        scan_row_t r;
        r.mode         = mode;
        r.element      = element;
        r.last_element = last_element;
        r.typed        = typed;
        r.want_value   = want_value;
        r.want_ovf     = want_ovf;
        return r;
    endfunction

    function automatic int idle_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7)
            return MODE_SUM;
        else if (r < 13)
            return MODE_MAX;
        else if (r < 19)
            return MODE_MIN;
        return MODE_UNUSED;
    endfunction

    function automatic logic signed [DATA_W-1:0] scan_operand(input bit wide);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return NA_CODE;
        else if (r < 7)
            return INT_MAX;
        else if (r < 11)
            return SUM_FLOOR;
        else if (r < 30)
            return $urandom;
        else if (r < (wide ? 70 : 38))
            return 32'($urandom_range(0, 32'h7fff_ffff)) - 32'h4000_0000;
        return 32'($urandom_range(0, 2000)) - 32'd1000;
    endfunction

    task automatic send_item(input ips_in_t it, input logic typed, input ips_out_t want);
        int       gap;
        ips_out_t pred;
        gap = idle_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        pred = predict_scan_result(it);
        pending_results.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic set_mode(input logic [1:0] m);
        logic [31:0] rd;
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_SCAN_MODE;
        pwdata  <= {30'b0, m};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        mode_q = m;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd != {30'b0, m})
            report_mismatch("scan_mode readback", rd, {30'b0, m});
    endtask

    always @(posedge aclk) begin
        if (steady_flow) begin
            m_ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 99) < 60) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            ready_hold <= ($urandom_range(0, 99) < 95) ? $urandom_range(0, 3)
                                                        : $urandom_range(10, 40);
        end
    end

    always @(posedge aclk) begin : result_check
        ips_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", m_item.running_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_item.running_value !== want.running_value)
                    report_mismatch("running_value", m_item.running_value,
                                    want.running_value);
                if (m_item.overflowed !== want.overflowed)
                    report_mismatch("overflowed", 32'(m_item.overflowed),
                                    32'(want.overflowed));
                if (m_item.last_result !== want.last_result)
                    report_mismatch("last_result", 32'(m_item.last_result),
                                    32'(want.last_result));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || psel || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        ips_in_t    item;
        ips_out_t   want;
        logic [1:0] m;
        int         len;
        bit         wide;

        dir_rows[0]  = mk_row(MODE_SUM, INT_MAX, 1'b1, 1'b1, INT_MAX, 1'b0);
        dir_rows[1]  = mk_row(MODE_SUM, SUM_FLOOR, 1'b1, 1'b1, SUM_FLOOR, 1'b0);
        dir_rows[2]  = mk_row(MODE_SUM, INT_MAX, 1'b0, 1'b0, '0, 1'b0);
        dir_rows[3]  = mk_row(MODE_SUM, 32'sd1, 1'b0, 1'b1, NA_CODE, 1'b1);
        dir_rows[4]  = mk_row(MODE_SUM, 32'sd5, 1'b1, 1'b1, NA_CODE, 1'b1);
        dir_rows[5]  = mk_row(MODE_SUM, NA_CODE, 1'b0, 1'b1, NA_CODE, 1'b0);
        dir_rows[6]  = mk_row(MODE_SUM, 32'sd3, 1'b1, 1'b1, NA_CODE, 1'b0);
        dir_rows[7]  = mk_row(MODE_SUM, SUM_FLOOR, 1'b0, 1'b0, '0, 1'b0);
        dir_rows[8]  = mk_row(MODE_SUM, -32'sd1, 1'b1, 1'b1, NA_CODE, 1'b1);
        dir_rows[9]  = mk_row(MODE_SUM, 32'sd0, 1'b0, 1'b1, 32'sd0, 1'b0);
        // mode change mid vector
        dir_rows[10] = mk_row(MODE_MAX, -32'sd5, 1'b0, 1'b0, '0, 1'b0);
        dir_rows[11] = mk_row(MODE_MAX, 32'sd7, 1'b1, 1'b0, '0, 1'b0);
        dir_rows[12] = mk_row(MODE_MAX, NA_CODE, 1'b0, 1'b1, NA_CODE, 1'b0);
        dir_rows[13] = mk_row(MODE_MAX, 32'sd9, 1'b1, 1'b1, NA_CODE, 1'b0);
        dir_rows[14] = mk_row(MODE_MAX, SUM_FLOOR, 1'b0, 1'b0, '0, 1'b0);
        dir_rows[15] = mk_row(MODE_MAX, INT_MAX, 1'b1, 1'b0, '0, 1'b0);
        dir_rows[16] = mk_row(MODE_MIN, INT_MAX, 1'b0, 1'b0, '0, 1'b0);
        dir_rows[17] = mk_row(MODE_MIN, SUM_FLOOR, 1'b0, 1'b0, '0, 1'b0);
        dir_rows[18] = mk_row(MODE_MIN, 32'sd4, 1'b1, 1'b0, '0, 1'b0);
        // overflow, then max in the same vector
        dir_rows[19] = mk_row(MODE_SUM, INT_MAX, 1'b0, 1'b0, '0, 1'b0);
        dir_rows[20] = mk_row(MODE_SUM, INT_MAX, 1'b0, 1'b1, NA_CODE, 1'b1);
        dir_rows[21] = mk_row(MODE_MAX, 32'sd1, 1'b1, 1'b1, NA_CODE, 1'b1);
        dir_rows[22] = mk_row(MODE_UNUSED, 32'sd8, 1'b0, 1'b1, NA_CODE, 1'b0);
        dir_rows[23] = mk_row(MODE_UNUSED, 32'sd8, 1'b1, 1'b1, NA_CODE, 1'b0);
        dir_rows[24] = mk_row(MODE_MIN, NA_CODE, 1'b1, 1'b1, NA_CODE, 1'b0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].mode != mode_q)
                set_mode(dir_rows[i].mode);
            item.element       = dir_rows[i].element;
            item.last_element  = dir_rows[i].last_element;
            want.running_value = dir_rows[i].want_value;
            want.overflowed    = dir_rows[i].want_ovf;
            want.last_result   = dir_rows[i].last_element;
            send_item(item, dir_rows[i].typed, want);
        end

        while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
            m = pick_mode();
            if (m != mode_q || $urandom_range(0, 7) == 0)
                set_mode(m);
            steady_flow = ($urandom_range(0, 4) == 0);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            wide = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++) begin
                if (k != 0 && $urandom_range(0, 39) == 0)
                    set_mode(pick_mode());
                item.element      = scan_operand(wide);
                item.last_element = (k == len - 1);
                send_item(item, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        steady_flow = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
